### src/disk_block_chs_remap_unit_assert.svh
// Assertion macros shared by the block's checker.
`ifndef DISK_BLOCK_CHS_REMAP_UNIT_ASSERT_SVH
`define DISK_BLOCK_CHS_REMAP_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, idle during reset.
`define DBCR_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, clocked on clk, idle during reset.
`define DBCR_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define DBCR_ASSERT_RST(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) else $error(msg);

`endif

### src/dbcr_pkg.sv
// Types and constants of the disk block CHS remap unit.
`default_nettype none
package dbcr_pkg;

  localparam int DIV_W      = 32;
  localparam int DVSR_W     = 8;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  localparam logic [1:0] ST_XLATE  = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_LOADED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SPT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HPC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TCYL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PSCYL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PBLK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TVLD  = 3'd5;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  entry_index;
    logic [15:0] entry_cylinder;
    logic [15:0] entry_track_sector;
    logic [30:0] block_number;
    logic [6:0]  sector_count;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  transfer_count;
    logic [31:0] absolute_block;
    logic [15:0] cylinder;
    logic [7:0]  head;
    logic [7:0]  sector;
    logic        is_remapped;
    logic [31:0] spare_block;
    logic [15:0] spare_cylinder;
    logic [7:0]  spare_head;
    logic [7:0]  spare_sector;
  } out_t;

  typedef struct packed {
    logic [15:0] cyl;
    logic [15:0] ts;
  } tbl_entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
    logic [DVSR_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLAMP,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_DIV1,
    S_DIV1_W,
    S_DIV2,
    S_DIV2_W,
    S_SRCH,
    S_SP_MUL1,
    S_SP_MUL2,
    S_SP_SUB,
    S_SDIV1,
    S_SDIV1_W,
    S_SDIV2,
    S_SDIV2_W,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

### src/disk_block_chs_remap_unit.sv
// Disk block CHS remap unit: sequencer, geometry registers and result register.
//
// Input channel in_valid/in_ready/in_data takes one request at a time. A load
// request (cmd 0) writes one bad-sector table entry; a translate request
// (cmd 1) clamps the count, adds the partition offset, splits the block into
// cylinder/head/sector and scans the bad-sector table for the first sector.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// always high. The user must make writes only while the unit is idle; the unit
// itself does not enforce it.
// Translation uses the shared 32-step divider (four divisions per remapped
// request); the table is scanned, only when marked valid, at one entry per
// cycle on its single read port.
// in_ready is high only while the sequencer is idle; the next request can be
// taken in the cycle after a result is registered.
// The result sits in an output register; a stalled receiver holds it, and the
// next request is accepted meanwhile, waiting at its end for the register.
// Reset (rst_n low at a clock edge) empties the table, drops any pending result
// and restores the default geometry.
`default_nettype none
module disk_block_chs_remap_unit #(
  parameter int TABLE_ENTRIES = 126,
  parameter int MAX_SECTORS   = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire dbcr_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output dbcr_pkg::out_t                        out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dbcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dbcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dbcr_pkg::*;

  localparam int          IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [8:0]  TBL_N   = 9'(TABLE_ENTRIES);
  localparam logic [8:0]  MAX_S   = 9'(MAX_SECTORS);

  state_t      state_r, state_nxt;
  in_t         in_r, in_nxt;
  out_t        res_r, res_nxt;
  out_t        out_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [IDX_W-1:0] sidx_r, sidx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic        iss_done_r, iss_done_nxt;
  logic        cmp_vld_r, cmp_vld_nxt;

  logic [7:0]  spt_r, hpc_r;
  logic [15:0] tcyl_r, pscyl_r;
  logic [30:0] pblk_r;
  logic        tvld_r;

  logic [7:0]  ns_eff, nh_eff;
  logic [31:0] mul_x;
  logic [7:0]  mul_y;
  logic [39:0] mul_p;
  logic [6:0]  cnt_sat, cnt_clamp;
  logic [31:0] avail;
  logic        past_end;
  logic        in_acc;
  logic        tbl_we;
  tbl_entry_t  tbl_wdata, tbl_rdata;
  logic        hit;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ns_eff = (spt_r == 8'd0) ? 8'd1 : spt_r;
  assign nh_eff = (hpc_r == 8'd0) ? 8'd1 : hpc_r;

  assign tbl_we = in_acc && (in_data.cmd == CMD_LOAD) &&
                  ({2'b00, in_data.entry_index} < TBL_N);
  assign tbl_wdata.cyl = in_data.entry_cylinder;
  assign tbl_wdata.ts  = in_data.entry_track_sector;

  assign cnt_sat   = ({2'b00, in_r.sector_count} > MAX_S) ? MAX_S[6:0] : in_r.sector_count;
  assign avail     = {1'b0, pblk_r} - {1'b0, in_r.block_number};
  assign past_end  = in_r.block_number >= pblk_r;
  assign cnt_clamp = ({25'd0, cnt_sat} > avail) ? avail[6:0] : cnt_sat;

  assign hit = cmp_vld_r && (tbl_rdata.cyl == res_r.cylinder) &&
               (tbl_rdata.ts == {res_r.head, res_r.sector});

  always_comb begin
    mul_x = 32'd0;
    mul_y = 8'd0;
    case (state_r)
      S_MUL1: begin
        mul_x = {16'd0, pscyl_r};
        mul_y = ns_eff;
      end
      S_MUL2: begin
        mul_x = prod_r;
        mul_y = nh_eff;
      end
      S_SP_MUL1: begin
        mul_x = {16'd0, tcyl_r};
        mul_y = nh_eff;
      end
      S_SP_MUL2: begin
        mul_x = tmp_r;
        mul_y = ns_eff;
      end
      default: begin
        mul_x = 32'd0;
        mul_y = 8'd0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  always_comb begin
    div_req.start    = state_r inside {S_DIV1, S_DIV2, S_SDIV1, S_SDIV2};
    div_req.dividend = tmp_r;
    div_req.divisor  = nh_eff;
    case (state_r)
      S_DIV1: begin
        div_req.dividend = res_r.absolute_block;
        div_req.divisor  = ns_eff;
      end
      S_SDIV1: begin
        div_req.dividend = res_r.spare_block;
        div_req.divisor  = ns_eff;
      end
      default: begin
        div_req.dividend = tmp_r;
        div_req.divisor  = nh_eff;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    prod_nxt      = prod_r;
    tmp_nxt       = tmp_r;
    sidx_nxt      = sidx_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    iss_done_nxt  = iss_done_r;
    cmp_vld_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          in_nxt  = in_data;
          res_nxt = '0;
          if (in_data.cmd == CMD_LOAD) begin
            res_nxt.status = ST_LOADED;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_CLAMP;
          end
        end
      end
      S_CLAMP: begin
        if (past_end || (cnt_clamp == 7'd0)) begin
          res_nxt.status = ST_EMPTY;
          state_nxt      = S_FIN;
        end else begin
          res_nxt.status         = ST_XLATE;
          res_nxt.transfer_count = cnt_clamp;
          state_nxt              = S_MUL1;
        end
      end
      S_MUL1: begin
        prod_nxt  = mul_p[31:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt  = mul_p[31:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        res_nxt.absolute_block = {1'b0, in_r.block_number} + prod_r;
        state_nxt              = S_DIV1;
      end
      S_DIV1: begin
        state_nxt = S_DIV1_W;
      end
      S_DIV1_W: begin
        if (div_rsp.done) begin
          res_nxt.sector = div_rsp.remainder;
          tmp_nxt        = div_rsp.quotient;
          state_nxt      = S_DIV2;
        end
      end
      S_DIV2: begin
        state_nxt = S_DIV2_W;
      end
      S_DIV2_W: begin
        if (div_rsp.done) begin
          res_nxt.cylinder = div_rsp.quotient[15:0];
          res_nxt.head     = div_rsp.remainder;
          sidx_nxt         = '0;
          iss_done_nxt     = 1'b0;
          state_nxt        = tvld_r ? S_SRCH : S_FIN;
        end
      end
      S_SRCH: begin
        if (!iss_done_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = sidx_r;
          if (sidx_r == LAST_IDX) begin
            iss_done_nxt = 1'b1;
          end else begin
            sidx_nxt = sidx_r + 1'b1;
          end
        end
        if (hit) begin
          hit_nxt             = cmp_idx_r;
          res_nxt.is_remapped = 1'b1;
          cmp_vld_nxt         = 1'b0;
          state_nxt           = S_SP_MUL1;
        end else if (cmp_vld_r && (cmp_idx_r == LAST_IDX)) begin
          state_nxt = S_FIN;
        end
      end
      S_SP_MUL1: begin
        tmp_nxt   = mul_p[31:0] - 32'd1;
        state_nxt = S_SP_MUL2;
      end
      S_SP_MUL2: begin
        tmp_nxt   = mul_p[31:0];
        state_nxt = S_SP_SUB;
      end
      S_SP_SUB: begin
        res_nxt.spare_block = tmp_r - {{(32-IDX_W){1'b0}}, hit_r} - 32'd1;
        state_nxt           = S_SDIV1;
      end
      S_SDIV1: begin
        state_nxt = S_SDIV1_W;
      end
      S_SDIV1_W: begin
        if (div_rsp.done) begin
          res_nxt.spare_sector = div_rsp.remainder;
          tmp_nxt              = div_rsp.quotient;
          state_nxt            = S_SDIV2;
        end
      end
      S_SDIV2: begin
        state_nxt = S_SDIV2_W;
      end
      S_SDIV2_W: begin
        if (div_rsp.done) begin
          res_nxt.spare_cylinder = div_rsp.quotient[15:0];
          res_nxt.spare_head     = div_rsp.remainder;
          state_nxt              = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      iss_done_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      sidx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      iss_done_r  <= iss_done_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      sidx_r      <= sidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    res_r     <= res_nxt;
    prod_r    <= prod_nxt;
    tmp_r     <= tmp_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_r     <= hit_nxt;
    if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= 8'd2;
      hpc_r   <= 8'd2;
      tcyl_r  <= 16'd2;
      pscyl_r <= 16'd0;
      pblk_r  <= 31'd0;
      tvld_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPT:   spt_r   <= cfg_data[7:0];
        REG_HPC:   hpc_r   <= cfg_data[7:0];
        REG_TCYL:  tcyl_r  <= cfg_data[15:0];
        REG_PSCYL: pscyl_r <= cfg_data[15:0];
        REG_PBLK:  pblk_r  <= cfg_data[30:0];
        REG_TVLD:  tvld_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dbcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dbcr_tbl #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (IDX_W'(in_data.entry_index)),
    .wr_data (tbl_wdata),
    .rd_addr (sidx_r),
    .rd_data (tbl_rdata)
  );

endmodule
`default_nettype wire

### src/dbcr_div.sv
// Shared restoring divider: 32-bit dividend by 8-bit divisor, one bit per cycle.
`default_nettype none
module dbcr_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dbcr_pkg::div_req_t req,
  output dbcr_pkg::div_rsp_t     rsp
);
  import dbcr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVSR_W-1:0]    rem_r, rem_nxt;
  logic [DVSR_W-1:0]    dsr_r, dsr_nxt;
  logic [DVSR_W:0]      shifted;
  logic [DVSR_W:0]      diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

### src/dbcr_tbl.sv
// Bad-sector table: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module dbcr_tbl #(
  parameter int ENTRIES = 126,
  parameter int IDX_W   = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire dbcr_pkg::tbl_entry_t wr_data,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output dbcr_pkg::tbl_entry_t      rd_data
);
  import dbcr_pkg::*;

  tbl_entry_t mem [ENTRIES];
  logic       vld_r [ENTRIES];
  tbl_entry_t q_r;
  logic       q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        vld_r[i] <= 1'b0;
      end
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      q_vld_r <= vld_r[rd_addr];
    end
  end

  // unwritten entries read as all ones
  assign rd_data = q_vld_r ? q_r : '1;

endmodule
`default_nettype wire

### src/dbcr_checker.sv
// Port-level checks of the disk block CHS remap unit, bound to the top level.
`default_nettype none
`include "disk_block_chs_remap_unit_assert.svh"
module dbcr_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire dbcr_pkg::in_t                    in_data,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire dbcr_pkg::out_t                   out_data,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [dbcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [dbcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dbcr_pkg::*;

  `DBCR_ASSERT_RST(a_reset_drops_out, !rst_n, !out_valid, "result valid after reset")
  `DBCR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `DBCR_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `DBCR_ASSERT_IMP(a_empty_zero, out_valid && (out_data.status != ST_XLATE), (out_data.transfer_count == 7'd0) && (out_data.absolute_block == 32'd0) && !out_data.is_remapped, "non-translate result has fields set")
  `DBCR_ASSERT_IMP(a_no_remap_zero, out_valid && !out_data.is_remapped, (out_data.spare_block == 32'd0) && (out_data.spare_cylinder == 16'd0) && (out_data.spare_head == 8'd0) && (out_data.spare_sector == 8'd0), "spare fields set without remap")

endmodule

bind disk_block_chs_remap_unit dbcr_checker u_dbcr_checker (.*);
`default_nettype wire
